### design/kprs_pkg.sv
// Shared types and tables for the keypad release scanner.
// Holds the token that travels along the cell chain, the visiting order and
// the character table. No dependencies.
package kprs_pkg;

  localparam int unsigned KEY_COUNT = 16;

  // Token handed from one cell to the next in each cycle.
  typedef struct packed {
    logic       valid;
    logic       found;
    logic [3:0] position;
  } token_t;

  // Key index column*4+row of the key visited at step k of a scan.
  // Rows run from 3 down to 0 and, within a row, columns from 0 to 3.
  function automatic logic [3:0] visit_index(input logic [3:0] k);
    return {k[1:0], ~k[3:2]};
  endfunction

  // ASCII character of each key, by index column*4+row.
  function automatic logic [6:0] key_char(input logic [3:0] idx);
    logic [6:0] ch;
    unique case (idx)
      4'd0:  ch = 7'h20; // space
      4'd1:  ch = 7'h30; // 0
      4'd2:  ch = 7'h3D; // =
      4'd3:  ch = 7'h2B; // +
      4'd4:  ch = 7'h34; // 4
      4'd5:  ch = 7'h35; // 5
      4'd6:  ch = 7'h36; // 6
      4'd7:  ch = 7'h2A; // *
      4'd8:  ch = 7'h37; // 7
      4'd9:  ch = 7'h38; // 8
      4'd10: ch = 7'h39; // 9
      4'd11: ch = 7'h2D; // -
      4'd12: ch = 7'h31; // 1
      4'd13: ch = 7'h32; // 2
      4'd14: ch = 7'h33; // 3
      4'd15: ch = 7'h2F; // /
    endcase
    return ch;
  endfunction

endpackage

### design/kprs_cell.sv
// One cell of the scan chain: holds the released flag of a single key.
// Depends on kprs_pkg for the token type.
module kprs_cell
  import kprs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] key_index,  // index column*4+row of the key this cell owns
  input  logic       level,      // sampled level of that key, 1 means not pressed
  input  token_t     tok_in,
  output token_t     tok_out
);

  logic   flag;
  logic   flag_next;
  token_t tok_next;

  // Compare the level with the stored flag while the token is here and no
  // release has been reported earlier in this scan.
  always_comb begin
    tok_next  = tok_in;
    flag_next = flag;
    if (tok_in.valid && !tok_in.found) begin
      if (!level && flag) begin
        flag_next = 1'b0;
      end else if (level && !flag) begin
        flag_next         = 1'b1;
        tok_next.found    = 1'b1;
        tok_next.position = key_index;
      end
    end
  end

  // Flag starts as released; the token moves on in every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag    <= 1'b1;
      tok_out <= '0;
    end else begin
      flag    <= flag_next;
      tok_out <= tok_next;
    end
  end

endmodule

### design/keypad_release_scanner_unit.sv
// Top level of the keypad release scanner: input capture, the chain of
// sixteen key cells and the output stage with its one-item skid slot.
// Depends on kprs_pkg and kprs_cell.
//
//   Channel   Direction  Contents
//   s_axis    in         key_levels (16 bits)
//   m_axis    out        key_found, key_code, key_position
//
// A result is presented once its scan has passed through the block: the accepting
// edge loads the levels and the start flag, the token then passes the registers of
// the 16 cells in turn, and the output register is loaded last. The token walk
// through the cell chain sets how long this takes. No new scan is taken until
// the result of the last one has left the cell chain, even if that result is still
// waiting; a second waiting result sits in the skid slot and holds the input off
// until it moves up.
// Reset (rst, synchronous) marks every key released and empties the block.
module keypad_release_scanner_unit
  import kprs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] key_levels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] key_found, [7:1] key_code,
                                      // [11:8] key_position, [15:12] zero
);

  logic        in_accept;
  logic        busy;
  logic        start;
  logic [15:0] levels;
  token_t      tok [KEY_COUNT+1];
  logic [KEY_COUNT-1:0] tok_valid;
  logic        pend_valid;
  logic [15:0] pend_data;
  logic [15:0] result;
  logic        out_free;
  logic        chain_done;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy && !pend_valid;
  assign chain_done    = tok[KEY_COUNT].valid;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Capture the scan and start the token in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= in_accept;
      if (in_accept) begin
        busy <= 1'b1;
      end else if (chain_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      levels <= s_axis_tdata;
    end
  end

  // Token entering the first cell.
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = start;
  end

  // The chain of cells, in visiting order.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_cell
    logic [3:0] idx;
    assign idx = visit_index(4'(k));

    kprs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .key_index (idx),
      .level     (levels[idx]),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1])
    );

    assign tok_valid[k] = tok[k+1].valid;
  end

  // Format the item leaving the chain; fields are zero when nothing was found.
  always_comb begin
    result = '0;
    if (tok[KEY_COUNT].found) begin
      result = {4'b0000, tok[KEY_COUNT].position,
                key_char(tok[KEY_COUNT].position), 1'b1};
    end
  end

  // Output register with a single skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (chain_done) begin
        if (out_free) begin
          m_axis_tvalid <= 1'b1;
        end else begin
          pend_valid <= 1'b1;
        end
      end else if (out_free) begin
        m_axis_tvalid <= pend_valid;
        pend_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain_done) begin
      if (out_free) begin
        m_axis_tdata <= result;
      end else begin
        pend_data <= result;
      end
    end else if (out_free && pend_valid) begin
      m_axis_tdata <= pend_data;
    end
  end

  // At most one token is ever travelling along the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell chain");

  // An accepted scan keeps the block busy until its token has left.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> busy && !s_axis_tready)
    else $error("scan accepted but block not busy");

  // A waiting item in the skid slot is kept while the output stays full.
  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend_valid && m_axis_tvalid && !m_axis_tready |=> pend_valid)
    else $error("skid item lost");

  // A result without a release carries all-zero fields.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[15:1] == 15'd0)
    else $error("non-zero fields on a result with no release");

endmodule

### tb/sv/keypad_release_scanner_unit_test.sv
// Self-checking testbench for keypad_release_scanner_unit.
// Drives key-level scans into the stream input and checks each result against
// a local model of the per-key release flags. Depends on the block only.
`timescale 1ns / 100ps

module keypad_release_scanner_unit_test;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned IDLE_PERCENT = 34;

  // Characters of the sixteen keys, index 0 in the leftmost position.
  localparam logic [8*16-1:0] KEY_GLYPHS = " 0=+456*789-123/";

  // One result item as the block should present it.
  typedef struct packed {
    logic       found;
    logic [6:0] code;
    logic [3:0] position;
  } key_event_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] key_levels
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] key_found, [7:1] key_code, [11:8] key_position

  logic [15:0] released_flags;
  key_event_t  expected_releases [$];
  int unsigned mismatch_count;
  bit          gaps_on;
  bit          stalls_on;

  keypad_release_scanner_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("** keypad_release_scanner_unit: FAILED **");
    $finish;
  end

  // Walks the keys in scan order: rows 3 down to 0, columns 0 to 3 within a
  // row. A fresh press clears the flag; the first release sets it again,
  // is reported and ends the walk for this scan.
  function automatic key_event_t predict_release(input logic [15:0] levels);
    key_event_t ev;
    int         row;
    int         col;
    int         idx;
    bit         stopped;
    ev      = '0;
    stopped = 1'b0;
    for (row = 3; row >= 0 && !stopped; row--) begin
      for (col = 0; col < 4 && !stopped; col++) begin
        idx = col * 4 + row;
        if (!levels[idx] && released_flags[idx]) begin
          released_flags[idx] = 1'b0;
        end else if (levels[idx] && !released_flags[idx]) begin
          released_flags[idx] = 1'b1;
          ev.found    = 1'b1;
          ev.code     = KEY_GLYPHS[8 * (15 - idx) +: 7];
          ev.position = idx[3:0];
          stopped     = 1'b1;
        end
      end
    end
    return ev;
  endfunction

  // Offers one scan, with random gaps beforehand, and records the expected
  // result once the item has been accepted.
  task automatic send_scan(input logic [15:0] levels);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= levels;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_releases.push_back(predict_release(levels));
  endtask

  task automatic release_bus;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_results;
    release_bus();
    while (expected_releases.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
  endtask

  // Idle pad, press-all, then every key released one scan at a time so that
  // each character appears in visiting order, then single-key corners.
  task automatic test_directed_scans;
    send_scan(16'hFFFF);
    send_scan(16'h0000);
    send_scan(16'h0000);
    repeat (16) send_scan(16'hFFFF);
    send_scan(16'hFFFF);
    send_scan(16'hFFFE);
    send_scan(16'hFFFF);
    send_scan(16'h7FFF);
    send_scan(16'h7FFF);
    send_scan(16'hFFFF);
  endtask

  // Realistic typing: keys are pressed, held over several scans and released,
  // with the odd burst of noise or a whole group of keys going down at once.
  task automatic test_key_sessions(input int unsigned count);
    logic [15:0] pressed;
    int unsigned roll;
    int unsigned n;
    pressed = '0;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        pressed[$urandom_range(0, 15)] = 1'b1;
      end else if (roll < 50) begin
        pressed[$urandom_range(0, 15)] = 1'b0;
      end else if (roll < 55) begin
        pressed = '0;
      end else if (roll < 60) begin
        pressed = pressed | 16'($urandom);
      end
      if (roll >= 92) begin
        send_scan(16'($urandom));
      end else begin
        send_scan(~pressed);
      end
    end
  endtask

  // A long stretch with both sides always ready.
  task automatic test_without_idling(input int unsigned count);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_key_sessions(count);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // The sender stops until the block has delivered everything, then resumes.
  task automatic test_drain_pause(input int unsigned count);
    test_key_sessions(count);
    wait_for_results();
    test_key_sessions(count);
  endtask

  task automatic test_random_levels(input int unsigned count);
    repeat (count) send_scan(16'($urandom));
  endtask

  // Receiver side: random back-pressure, set up at the falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= stalls_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_releases.size() == 0) begin
        note_failure($sformatf("unexpected result item, data %h", m_axis_tdata));
      end else begin
        want = expected_releases.pop_front();
        if (m_axis_tdata[0] !== want.found || m_axis_tdata[7:1] !== want.code ||
            m_axis_tdata[11:8] !== want.position || m_axis_tdata[15:12] !== 4'h0) begin
          note_failure($sformatf(
            "result mismatch: expected found=%0d code=%h pos=%0d pad=0, got %0d %h %0d %h",
            want.found, want.code, want.position, m_axis_tdata[0], m_axis_tdata[7:1],
            m_axis_tdata[11:8], m_axis_tdata[15:12]));
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    released_flags = '1;
    mismatch_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_scans();
    test_key_sessions(700);
    test_without_idling(300);
    test_drain_pause(100);
    test_random_levels(600);

    // Let the last results come out, then allow a little extra time.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_releases.size() == 0) begin
      $display("** keypad_release_scanner_unit: PASSED **");
    end else begin
      $display("** keypad_release_scanner_unit: FAILED **");
    end
    $finish;
  end

endmodule

### keypad_release_scanner_unit.f
design/kprs_pkg.sv
design/kprs_cell.sv
design/keypad_release_scanner_unit.sv
tb/sv/keypad_release_scanner_unit_test.sv
